/* design/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and helper functions of the chunk window scroller.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int MAX_RADIUS = 3;
  localparam int SLOT_BITS  = 6;

  localparam logic [31:0]        COORD_MAX = 32'h7fff_ffff;
  localparam logic signed [48:0] SAT_HI    = 49'sd2147483647;
  localparam logic signed [48:0] SAT_LO    = -49'sd2147483648;

  typedef logic [1:0] radius_t;
  typedef logic [2:0] mod_t;

  typedef struct packed {
    radius_t     radius;   // already clamped to 1..MAX_RADIUS
    logic [15:0] extent;   // already forced nonzero
  } cfg_t;

  // One unit of back-end work, built by the front end.
  typedef struct packed {
    logic        do_init;
    logic        do_x;
    logic        do_z;
    radius_t     radius;
    logic [15:0] extent;
    logic [31:0] cx0;      // centre x - R
    logic [31:0] cz0;      // centre z - R
    logic [31:0] nx;       // entering column
    logic [31:0] nz;       // entering row
    mod_t        mx0;
    mod_t        mz0;
    mod_t        oxm;      // slot column of the leaving column
    mod_t        ozm;      // slot row of the leaving row
  } job_t;

  // grid side S = 2R+1
  function automatic mod_t grid_side(radius_t r);
    return {r, 1'b1};
  endfunction

  // S-1 = 2R, last counter value along a side
  function automatic mod_t side_last(radius_t r);
    return {r, 1'b0};
  endfunction

  // floormod(-2^31, S)
  function automatic mod_t min_mod(radius_t r);
    mod_t m;
    case (r)
      2'd1:    m = 3'd1;
      2'd2:    m = 3'd2;
      2'd3:    m = 3'd5;
      default: m = 3'd1;
    endcase
    return m;
  endfunction

  // 2^32 mod S
  function automatic mod_t wrap_mod(radius_t r);
    mod_t m;
    case (r)
      2'd1:    m = 3'd1;
      2'd2:    m = 3'd1;
      2'd3:    m = 3'd4;
      default: m = 3'd1;
    endcase
    return m;
  endfunction

  // (rem*16 + nib) mod S, rem < S
  function automatic mod_t mod_step(mod_t rem, logic [3:0] nib, radius_t r);
    logic [6:0] t;
    logic [6:0] gs;
    t = {rem, nib};
    for (int k = 3; k >= 0; k--) begin
      gs = 7'(grid_side(r)) << k;
      if (t >= gs) begin
        t = t - gs;
      end
    end
    return t[2:0];
  endfunction

  // unsigned residue of the raw bits -> floor residue of the signed value
  function automatic mod_t mod_fix(mod_t um, logic sign, radius_t r);
    logic [3:0] s;
    s = {1'b0, um} + {1'b0, grid_side(r)} - {1'b0, wrap_mod(r)};
    if (!sign) begin
      return um;
    end
    if (um >= wrap_mod(r)) begin
      return um - wrap_mod(r);
    end
    return s[2:0];
  endfunction

  // residue of v+1, given residue m of v; the coordinate wraps at 2^32
  function automatic mod_t mod_inc(logic [31:0] v, mod_t m, radius_t r);
    if (v == COORD_MAX) begin
      return min_mod(r);
    end
    if (m == side_last(r)) begin
      return 3'd0;
    end
    return m + 3'd1;
  endfunction

  function automatic logic [31:0] sat32(logic signed [48:0] p);
    if (p > SAT_HI) begin
      return 32'h7fff_ffff;
    end
    if (p < SAT_LO) begin
      return 32'h8000_0000;
    end
    return p[31:0];
  endfunction

endpackage

/* design/tcw_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_stream_if
// Valid/ready channels: viewer positions in, slot assignments out.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_z;

  modport source (output valid, func, pos_x, pos_z, input ready);
  modport sink   (input valid, func, pos_x, pos_z, output ready);
endinterface

interface tcw_out_if;
  logic                                valid;
  logic                                ready;
  logic [tcw_pkg::SLOT_BITS-1:0]       slot_index;
  logic signed [31:0]                  chunk_x;
  logic signed [31:0]                  chunk_z;
  logic signed [31:0]                  origin_x;
  logic signed [31:0]                  origin_z;
  logic                                last;

  modport source (output valid, slot_index, chunk_x, chunk_z, origin_x, origin_z, last,
                  input ready);
  modport sink   (input valid, slot_index, chunk_x, chunk_z, origin_x, origin_z, last,
                  output ready);
endinterface

/* design/tcw_floor_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_floor_div
// Iterative floor division of a signed 32-bit value by a nonzero 16-bit
// unsigned divisor, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tcw_floor_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);

  logic        busy;
  logic [3:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic [31:0] dq;
  logic        neg;

  logic [16:0] t1, t2;
  logic [15:0] r1, r2;
  logic        q1, q2;
  logic [31:0] dq_next;
  logic [31:0] fin;

  always_comb begin
    t1 = {rem, dq[31]};
    if (t1 >= {1'b0, dsr}) begin
      r1 = 16'(t1 - {1'b0, dsr});
      q1 = 1'b1;
    end else begin
      r1 = t1[15:0];
      q1 = 1'b0;
    end
    t2 = {r1, dq[30]};
    if (t2 >= {1'b0, dsr}) begin
      r2 = 16'(t2 - {1'b0, dsr});
      q2 = 1'b1;
    end else begin
      r2 = t2[15:0];
      q2 = 1'b0;
    end
    dq_next = {dq[29:0], q1, q2};
    // negative dividend: quotient of the magnitude, negated, rounded down
    fin = neg ? (32'd0 - dq_next - {31'd0, r2 != 16'd0}) : dq_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 16'd0;
      dsr <= divisor;
      neg <= dividend[31];
      dq  <= dividend[31] ? (32'd0 - dividend) : dividend;
    end else if (busy) begin
      rem <= r2;
      dq  <= dq_next;
      if (cnt == 4'd15) begin
        quotient <= fin;
      end
    end
  end

endmodule

/* design/tcw_job_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_job_queue
// Two-entry queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module tcw_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output tcw_pkg::job_t rd_job,
  output logic          empty
);

  tcw_pkg::job_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = count == 2'd2;
  assign empty  = count == 2'd0;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

endmodule

/* design/tcw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Takes positions, finds their chunks, compares with the centre and builds
// the job of slots to refresh, with the slot residues precomputed.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic          clk,
  input  logic          rst,
  input  tcw_pkg::cfg_t cfg,
  tcw_in_if.sink        in_ch,
  output logic          push,
  output tcw_pkg::job_t job,
  input  logic          full
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_DIV   = 3'd1;
  localparam logic [2:0] F_CLASS = 3'd2;
  localparam logic [2:0] F_MOD   = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [2:0]  state;
  logic        func_q;
  logic [1:0]  rad_q;
  logic [15:0] ext_q;
  logic [31:0] centre_x, centre_z;
  logic        div_start;
  logic [31:0] qx, qz;
  logic        done_x, done_z;
  logic [2:0]  cnt;

  logic        do_init, do_x, do_z;
  logic [31:0] cx0, cz0, nx, nz;
  logic [31:0] sh   [4];
  logic        sgn  [4];
  tcw_pkg::mod_t rem [4];

  logic [31:0] rr;
  logic        gt_x, gt_z, chg_x, chg_z;

  assign in_ch.ready = state == F_IDLE;
  assign div_start   = in_ch.valid && in_ch.ready;

  tcw_floor_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_ch.pos_x),
    .divisor  (cfg.extent),
    .quotient (qx),
    .done     (done_x)
  );

  tcw_floor_div u_div_z (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_ch.pos_z),
    .divisor  (cfg.extent),
    .quotient (qz),
    .done     (done_z)
  );

  always_comb begin
    rr    = {30'd0, rad_q};
    gt_x  = $signed(qx) > $signed(centre_x);
    gt_z  = $signed(qz) > $signed(centre_z);
    chg_x = qx != centre_x;
    chg_z = qz != centre_z;
  end

  assign push = state == F_PUSH && !full;

  always_comb begin
    job.do_init = do_init;
    job.do_x    = do_x;
    job.do_z    = do_z;
    job.radius  = rad_q;
    job.extent  = ext_q;
    job.cx0     = cx0;
    job.cz0     = cz0;
    job.nx      = nx;
    job.nz      = nz;
    job.mx0     = tcw_pkg::mod_fix(rem[0], sgn[0], rad_q);
    job.mz0     = tcw_pkg::mod_fix(rem[1], sgn[1], rad_q);
    job.oxm     = tcw_pkg::mod_fix(rem[2], sgn[2], rad_q);
    job.ozm     = tcw_pkg::mod_fix(rem[3], sgn[3], rad_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      centre_x <= 32'd0;
      centre_z <= 32'd0;
    end else begin
      case (state)
        F_IDLE: begin
          if (div_start) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (done_x && done_z) begin
            state <= F_CLASS;
          end
        end
        F_CLASS: begin
          // an unchanged chunk leaves the centre as it is, so always take the new one
          centre_x <= qx;
          centre_z <= qz;
          if (!func_q || chg_x || chg_z) begin
            state <= F_MOD;
          end else begin
            state <= F_IDLE;
          end
        end
        F_MOD: begin
          if (cnt == 3'd7) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      func_q <= in_ch.func;
      rad_q  <= cfg.radius;
      ext_q  <= cfg.extent;
    end
    case (state)
      F_CLASS: begin
        do_init <= !func_q;
        do_x    <= func_q && chg_x;
        do_z    <= func_q && chg_z;
        cx0     <= qx - rr;
        cz0     <= qz - rr;
        nx      <= gt_x ? qx + rr : qx - rr;
        nz      <= gt_z ? qz + rr : qz - rr;
        sh[0]   <= qx - rr;
        sh[1]   <= qz - rr;
        sh[2]   <= gt_x ? centre_x - rr : centre_x + rr;
        sh[3]   <= gt_z ? centre_z - rr : centre_z + rr;
        sgn[0]  <= 1'(({32'd0} | (qx - rr)) >> 31);
        sgn[1]  <= 1'((qz - rr) >> 31);
        sgn[2]  <= 1'((gt_x ? centre_x - rr : centre_x + rr) >> 31);
        sgn[3]  <= 1'((gt_z ? centre_z - rr : centre_z + rr) >> 31);
        for (int l = 0; l < 4; l++) begin
          rem[l] <= 3'd0;
        end
        cnt <= 3'd0;
      end
      F_MOD: begin
        // residue of the raw bits, one nibble a cycle, msb first
        for (int l = 0; l < 4; l++) begin
          rem[l] <= tcw_pkg::mod_step(rem[l], sh[l][31:28], rad_q);
          sh[l]  <= sh[l] << 4;
        end
        cnt <= cnt + 3'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/tcw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Walks a job slot by slot: init grid, leaving column, leaving row. Forms
// the slot number and the saturated chunk origins and presents each result.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic          clk,
  input  logic          rst,
  input  tcw_pkg::job_t rd_job,
  input  logic          empty,
  output logic          pop,
  tcw_out_if.source     out_ch
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_SAT  = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  localparam logic [1:0] PH_INIT = 2'd0;
  localparam logic [1:0] PH_X    = 2'd1;
  localparam logic [1:0] PH_Z    = 2'd2;

  logic [1:0]    state;
  logic [1:0]    phase;
  tcw_pkg::job_t job_q;
  logic [2:0]    ix, iz;
  logic [31:0]   x, z;
  tcw_pkg::mod_t mx, mz;

  logic                          valid_q;
  logic                          last_q;
  logic [tcw_pkg::SLOT_BITS-1:0] slot_q;
  logic [31:0]                   chunk_x_q, chunk_z_q;
  logic signed [48:0]            prod_x, prod_z;
  logic [31:0]                   origin_x_q, origin_z_q;

  tcw_pkg::mod_t sx, sz;
  logic [31:0]   chx, chz;
  logic          last_ix, last_iz, phase_end, run_end;

  assign pop = state == B_IDLE && !empty;

  always_comb begin
    sx  = mx;
    sz  = mz;
    chx = x;
    chz = z;
    case (phase)
      PH_X: begin
        sx  = job_q.oxm;
        chx = job_q.nx;
      end
      PH_Z: begin
        sz  = job_q.ozm;
        chz = job_q.nz;
      end
      default: begin
      end
    endcase
    last_ix = ix == tcw_pkg::side_last(job_q.radius);
    last_iz = iz == tcw_pkg::side_last(job_q.radius);
    case (phase)
      PH_INIT: phase_end = last_ix && last_iz;
      PH_X:    phase_end = last_iz;
      PH_Z:    phase_end = last_ix;
      default: phase_end = 1'b1;
    endcase
    run_end = phase_end && !(phase == PH_X && job_q.do_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      valid_q <= 1'b0;
      phase   <= PH_INIT;
    end else begin
      case (state)
        B_IDLE: begin
          if (!empty) begin
            state <= B_MUL;
            if (rd_job.do_init) begin
              phase <= PH_INIT;
            end else if (rd_job.do_x) begin
              phase <= PH_X;
            end else begin
              phase <= PH_Z;
            end
          end
        end
        B_MUL: begin
          state <= B_SAT;
          if (phase == PH_X && last_iz) begin
            phase <= PH_Z;
          end
        end
        B_SAT: begin
          state   <= B_OUT;
          valid_q <= 1'b1;
        end
        B_OUT: begin
          if (out_ch.ready) begin
            valid_q <= 1'b0;
            state   <= last_q ? B_IDLE : B_MUL;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!empty) begin
          job_q <= rd_job;
          ix    <= 3'd0;
          iz    <= 3'd0;
          x     <= rd_job.cx0;
          z     <= rd_job.cz0;
          mx    <= rd_job.mx0;
          mz    <= rd_job.mz0;
        end
      end
      B_MUL: begin
        slot_q    <= 6'(sx) + 6'(sz) * 6'(tcw_pkg::grid_side(job_q.radius));
        chunk_x_q <= chx;
        chunk_z_q <= chz;
        prod_x    <= 49'($signed(chx)) * 49'($signed({1'b0, job_q.extent}));
        prod_z    <= 49'($signed(chz)) * 49'($signed({1'b0, job_q.extent}));
        last_q    <= run_end;
        // step to the next slot of the walk
        case (phase)
          PH_INIT: begin
            if (last_ix) begin
              ix <= 3'd0;
              x  <= job_q.cx0;
              mx <= job_q.mx0;
              iz <= iz + 3'd1;
              z  <= z + 32'd1;
              mz <= tcw_pkg::mod_inc(z, mz, job_q.radius);
            end else begin
              ix <= ix + 3'd1;
              x  <= x + 32'd1;
              mx <= tcw_pkg::mod_inc(x, mx, job_q.radius);
            end
          end
          PH_X: begin
            iz <= iz + 3'd1;
            z  <= z + 32'd1;
            mz <= tcw_pkg::mod_inc(z, mz, job_q.radius);
          end
          PH_Z: begin
            ix <= ix + 3'd1;
            x  <= x + 32'd1;
            mx <= tcw_pkg::mod_inc(x, mx, job_q.radius);
          end
          default: begin
          end
        endcase
      end
      B_SAT: begin
        origin_x_q <= tcw_pkg::sat32(prod_x);
        origin_z_q <= tcw_pkg::sat32(prod_z);
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid      = valid_q;
  assign out_ch.slot_index = slot_q;
  assign out_ch.chunk_x    = chunk_x_q;
  assign out_ch.chunk_z    = chunk_z_q;
  assign out_ch.origin_x   = origin_x_q;
  assign out_ch.origin_z   = origin_z_q;
  assign out_ch.last       = last_q;

endmodule

/* design/toroidal_chunk_window_scroller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_chunk_window_scroller
// Toroidal window of chunk slots around a viewer: init fills the grid,
// updates re-aim the column and row that leave the window.
// ----------------------------------------------------------------------------
//  channel  dir  transfer carries
//  in_ch    in   func, pos_x, pos_z
//  out_ch   out  slot_index, chunk_x, chunk_z, origin_x, origin_z, last
//  wr_*     in   register index 0 = render_radius, 1 = chunk_extent
//
//  Front end: one accepted position at a time, through accept, the two parallel
//  floor dividers, classify, the nibble-serial slot residues and push (which waits
//  while the queue is full); an unchanged chunk returns to idle after classify.
//  Back end: pops a job, then takes each result through multiply, saturate and
//  output, holding in output while the receiver stalls; a run is 3 to 49 results.
//  A two-job queue lets the front take new positions while the back drains.
//  Synchronous reset: radius 1, extent 256, centre chunk (0, 0), queue empty.
// ----------------------------------------------------------------------------
module toroidal_chunk_window_scroller (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  tcw_in_if.sink      in_ch,
  tcw_out_if.source   out_ch
);

  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_EXTENT = 1'b1;

  logic [1:0]    render_radius;
  logic [15:0]   chunk_extent;
  tcw_pkg::cfg_t cfg_now;

  logic          push, pop, full, empty;
  tcw_pkg::job_t wr_job, rd_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      render_radius <= 2'd1;
      chunk_extent  <= 16'd256;
    end else if (wr_en) begin
      case (wr_index)
        REG_RADIUS: render_radius <= wr_data[1:0];
        REG_EXTENT: chunk_extent  <= wr_data;
        default:    render_radius <= render_radius;
      endcase
    end
  end

  // radius 0 acts as 1, extent 0 acts as 1
  always_comb begin
    if (render_radius == 2'd0) begin
      cfg_now.radius = 2'd1;
    end else if (32'(render_radius) > tcw_pkg::MAX_RADIUS) begin
      cfg_now.radius = 2'(tcw_pkg::MAX_RADIUS);
    end else begin
      cfg_now.radius = render_radius;
    end
    cfg_now.extent = (chunk_extent == 16'd0) ? 16'd1 : chunk_extent;
  end

  tcw_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_now),
    .in_ch (in_ch),
    .push  (push),
    .job   (wr_job),
    .full  (full)
  );

  tcw_job_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .full   (full),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (empty)
  );

  tcw_back u_back (
    .clk    (clk),
    .rst    (rst),
    .rd_job (rd_job),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* dv/tb_toroidal_chunk_window_scroller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_toroidal_chunk_window_scroller
// Self-checking bench for the chunk window scroller. A directed part covers
// field extremes, update before init, unchanged chunks, multi-chunk jumps,
// coordinate wrap, origin saturation and out-of-range register values. A
// random part then walks a viewer around under several radius/extent
// settings. Each accepted position is run through a local slot predictor,
// and every slot transfer is checked field by field against it. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_toroidal_chunk_window_scroller;

  typedef enum logic {FUNC_INIT = 1'b0, FUNC_UPDATE = 1'b1} func_e;
  typedef enum logic {REG_RADIUS = 1'b0, REG_EXTENT = 1'b1} reg_e;

  typedef struct packed {
    logic [tcw_pkg::SLOT_BITS-1:0] slot_index;
    logic [31:0]                   chunk_x;
    logic [31:0]                   chunk_z;
    logic [31:0]                   origin_x;
    logic [31:0]                   origin_z;
    logic                          last;
  } slot_rec_t;

  typedef struct {
    logic               fn;
    logic signed [31:0] px;
    logic signed [31:0] pz;
  } pos_item_t;

  localparam longint I32_MAX      = 64'sd2147483647;
  localparam longint I32_MIN      = -64'sd2147483648;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     CYCLE_LIMIT   = 4000000;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic        wr_index;
  logic [15:0] wr_data;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();

  toroidal_chunk_window_scroller dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // local copy of registers and window centre
  logic [1:0]  cfg_radius = 2'd1;
  logic [15:0] cfg_extent = 16'd256;
  longint      centre_x   = 0;
  longint      centre_z   = 0;

  pos_item_t   pending_pos[$];
  slot_rec_t   expected_slots[$];
  pos_item_t   next_pos;
  slot_rec_t   got_slot;
  slot_rec_t   want_slot;

  bit          no_idle        = 1'b0;
  int          send_gap       = 0;
  int          recv_stall     = 0;
  int          errors         = 0;
  int          items_queued   = 0;
  int          items_accepted = 0;
  int          init_count     = 0;
  int          update_count   = 0;
  int          results_seen   = 0;
  int          reg_writes     = 0;
  int          cycle_count    = 0;

  logic signed [31:0] gen_x;
  logic signed [31:0] gen_z;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint wrap32(longint v);
    logic signed [31:0] t;
    t = v[31:0];
    return longint'(t);
  endfunction

  function automatic longint floor_div(longint p, longint e);
    longint q;
    q = p / e;
    if ((p % e) != 0 && p < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint floor_mod(longint v, longint g);
    longint m;
    m = v % g;
    if (m < 0) m = m + g;
    return m;
  endfunction

  function automatic logic [31:0] origin_of(longint c, longint e);
    longint o;
    o = c * e;
    if (o > I32_MAX) o = I32_MAX;
    if (o < I32_MIN) o = I32_MIN;
    return o[31:0];
  endfunction

  function automatic slot_rec_t make_slot(longint sx, longint sz, longint cx, longint cz,
                                          longint r, longint e);
    slot_rec_t rec;
    longint    g;
    g              = 2 * r + 1;
    rec.slot_index = tcw_pkg::SLOT_BITS'(floor_mod(sx, g) + floor_mod(sz, g) * g);
    rec.chunk_x    = cx[31:0];
    rec.chunk_z    = cz[31:0];
    rec.origin_x   = origin_of(cx, e);
    rec.origin_z   = origin_of(cz, e);
    rec.last       = 1'b0;
    return rec;
  endfunction

  task automatic predict_slots(input logic fn, input logic signed [31:0] px,
                               input logic signed [31:0] pz);
    slot_rec_t run[$];
    longint    r, e, cx, cz, d, nx, ox, nz, oz, i, j;
    r = (cfg_radius == 0) ? 1 : longint'(cfg_radius);
    if (r > tcw_pkg::MAX_RADIUS) r = tcw_pkg::MAX_RADIUS;
    e  = (cfg_extent == 0) ? 1 : longint'(cfg_extent);
    cx = wrap32(floor_div(longint'(px), e));
    cz = wrap32(floor_div(longint'(pz), e));
    if (fn == FUNC_INIT) begin
      init_count++;
      centre_x = cx;
      centre_z = cz;
      for (j = -r; j <= r; j++) begin
        for (i = -r; i <= r; i++) begin
          run.push_back(make_slot(wrap32(cx + i), wrap32(cz + j),
                                  wrap32(cx + i), wrap32(cz + j), r, e));
        end
      end
    end else begin
      update_count++;
      if (cx != centre_x) begin
        d  = (cx > centre_x) ? 1 : -1;
        nx = wrap32(cx + r * d);
        ox = wrap32(centre_x - r * d);
        for (j = -r; j <= r; j++) begin
          run.push_back(make_slot(ox, wrap32(cz + j), nx, wrap32(cz + j), r, e));
        end
        centre_x = cx;
      end
      if (cz != centre_z) begin
        d  = (cz > centre_z) ? 1 : -1;
        nz = wrap32(cz + r * d);
        oz = wrap32(centre_z - r * d);
        for (i = -r; i <= r; i++) begin
          run.push_back(make_slot(wrap32(cx + i), oz, wrap32(cx + i), nz, r, e));
        end
        centre_z = cz;
      end
    end
    if (run.size() != 0) run[run.size() - 1].last = 1'b1;
    foreach (run[k]) expected_slots.push_back(run[k]);
  endtask

  // ------------------------------------------------------------------ helpers
  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
      return 1;
    end
    return 0;
  endfunction

  // ------------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
      centre_x    = 0;
      centre_z    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_slots(in_ch.func, in_ch.pos_x, in_ch.pos_z);
        items_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap    <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_pos.size() != 0) begin
          next_pos     = pending_pos.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func  <= next_pos.fn;
          in_ch.pos_x <= next_pos.px;
          in_ch.pos_z <= next_pos.pz;
          send_gap    <= no_idle ? 0 : gap_len();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_slot.slot_index = out_ch.slot_index;
        got_slot.chunk_x    = out_ch.chunk_x;
        got_slot.chunk_z    = out_ch.chunk_z;
        got_slot.origin_x   = out_ch.origin_x;
        got_slot.origin_z   = out_ch.origin_z;
        got_slot.last       = out_ch.last;
        if (expected_slots.size() == 0) begin
          $display("%0t ns: slot transfer with none expected, slot %0d chunk %0h,%0h",
                   $time, got_slot.slot_index, got_slot.chunk_x, got_slot.chunk_z);
          errors++;
        end else begin
          want_slot = expected_slots.pop_front();
          results_seen++;
          errors += check_field("slot_index", 32'(want_slot.slot_index),
                                32'(got_slot.slot_index));
          errors += check_field("chunk_x", want_slot.chunk_x, got_slot.chunk_x);
          errors += check_field("chunk_z", want_slot.chunk_z, got_slot.chunk_z);
          errors += check_field("origin_x", want_slot.origin_x, got_slot.origin_x);
          errors += check_field("origin_z", want_slot.origin_z, got_slot.origin_z);
          errors += check_field("last", 32'(want_slot.last), 32'(got_slot.last));
        end
      end
      if (recv_stall > 0) begin
        recv_stall   <= recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        recv_stall   <= gap_len();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d slots still expected",
               cycle_count, expected_slots.size());
      $display("toroidal_chunk_window_scroller: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic queue_pos(input logic fn, input logic signed [31:0] px,
                           input logic signed [31:0] pz);
    pos_item_t it;
    it.fn = fn;
    it.px = px;
    it.pz = pz;
    pending_pos.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(input reg_e idx, input logic [15:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    if (idx == REG_RADIUS) cfg_radius = data[1:0];
    else cfg_extent = data;
    reg_writes++;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // block idle: all positions taken, all slots seen, and a no-result update
  // given time to clear the front end
  task automatic settle();
    while (items_accepted != items_queued || expected_slots.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int step_of(int e);
    int p, s;
    p = $urandom_range(0, 9);
    if (p < 3) s = 0;
    else if (p < 8) s = int'($urandom_range(0, e));
    else if (p < 9) s = int'($urandom_range(0, 2 * e));
    else s = int'($urandom_range(0, 8 * e));
    if ($urandom_range(0, 1)) s = -s;
    return s;
  endfunction

  // random viewer walk: inits followed by runs of small moves, some noise
  task automatic walk(input int count);
    int p, e;
    e = (cfg_extent == 0) ? 1 : int'(cfg_extent);
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      if (p < 8) begin
        queue_pos($urandom_range(0, 1) ? FUNC_UPDATE : FUNC_INIT, $urandom, $urandom);
      end else if (p < 16 || k == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          gen_x = $urandom;
          gen_z = $urandom;
        end else begin
          gen_x = int'($urandom_range(0, 100 * e)) - 50 * e;
          gen_z = int'($urandom_range(0, 100 * e)) - 50 * e;
        end
        queue_pos(FUNC_INIT, gen_x, gen_z);
      end else begin
        gen_x = gen_x + step_of(e);
        gen_z = gen_z + step_of(e);
        queue_pos(FUNC_UPDATE, gen_x, gen_z);
      end
    end
  endtask

  task automatic run_phase(input logic [1:0] radius, input logic [15:0] extent,
                           input bit quiet, input int count);
    write_reg(REG_RADIUS, {14'd0, radius});
    write_reg(REG_EXTENT, extent);
    no_idle = quiet;
    walk(count);
    settle();
  endtask

  initial begin
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = REG_RADIUS;
    wr_data      = 16'd0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_INIT;
    in_ch.pos_x  = 32'sd0;
    in_ch.pos_z  = 32'sd0;
    out_ch.ready = 1'b0;
    gen_x        = 32'sd0;
    gen_z        = 32'sd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset registers: radius 1, extent 256
    queue_pos(FUNC_UPDATE, 32'sd600, -32'sd300);     // update before any init
    queue_pos(FUNC_INIT, 32'sd0, 32'sd0);
    queue_pos(FUNC_UPDATE, 32'sd100, 32'sd200);      // same chunk, no slots
    queue_pos(FUNC_UPDATE, 32'sd300, 32'sd200);
    queue_pos(FUNC_UPDATE, 32'sd300, -32'sd1);
    queue_pos(FUNC_UPDATE, -32'sd600, 32'sd700);     // jump on both axes
    queue_pos(FUNC_INIT, 32'h7fff_ffff, 32'h8000_0000);
    queue_pos(FUNC_UPDATE, 32'h8000_0000, 32'h7fff_ffff);
    settle();

    // widest window, largest extent: origins saturate at the extremes
    write_reg(REG_RADIUS, 16'd3);
    write_reg(REG_EXTENT, 16'hffff);
    queue_pos(FUNC_INIT, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_pos(FUNC_UPDATE, 32'h7fff_ffff - 32'sd65535, 32'h7fff_ffff);
    queue_pos(FUNC_INIT, 32'h8000_0000, 32'h8000_0000);
    queue_pos(FUNC_UPDATE, 32'h8000_0000 + 32'sd131070, 32'h8000_0000 + 32'sd65535);
    settle();

    // extent 1: chunk coordinates wrap around the 32-bit range
    write_reg(REG_RADIUS, 16'd2);
    write_reg(REG_EXTENT, 16'd1);
    queue_pos(FUNC_INIT, 32'h7fff_ffff, 32'h8000_0000);
    queue_pos(FUNC_UPDATE, 32'h8000_0000, 32'h7fff_ffff);
    queue_pos(FUNC_UPDATE, 32'h8000_0001, 32'h7fff_fffe);
    settle();

    // radius 0 acts as 1, extent 0 acts as 1
    write_reg(REG_RADIUS, 16'd0);
    write_reg(REG_EXTENT, 16'd0);
    queue_pos(FUNC_INIT, -32'sd1, 32'sd1);
    queue_pos(FUNC_UPDATE, 32'sd2, -32'sd2);
    queue_pos(FUNC_UPDATE, 32'sd2, -32'sd2);
    settle();

    // radius grows with no fresh init
    write_reg(REG_RADIUS, 16'd3);
    queue_pos(FUNC_UPDATE, 32'sd5, 32'sd5);
    queue_pos(FUNC_UPDATE, -32'sd5, 32'sd9);
    settle();

    run_phase(2'd3, 16'd256, 1'b0, 42);
    run_phase(2'd1, 16'($urandom), 1'b1, 42);
    run_phase(2'd2, 16'd1, 1'b0, 42);
    run_phase(2'd3, 16'd0, 1'b0, 40);
    run_phase(2'd0, 16'hffff, 1'b1, 40);
    run_phase(2'd2, 16'($urandom_range(1, 16)), 1'b0, 42);
    run_phase(2'd1, 16'($urandom_range(2, 1000)), 1'b0, 42);
    run_phase(2'd3, 16'($urandom), 1'b0, 42);

    $display("ran %0d positions (%0d init, %0d update) over %0d register writes",
             items_accepted, init_count, update_count, reg_writes);
    $display("checked %0d slot transfers, %0d field errors", results_seen, errors);
    if (errors == 0) begin
      $display("toroidal_chunk_window_scroller: match");
    end else begin
      $display("toroidal_chunk_window_scroller: mismatch");
    end
    $finish;
  end

endmodule
